[rtl/d8fd_pkg.sv]
// Shared widths, codes, types and constants of the D8 flow direction window.
`timescale 1ns / 1ps

package d8fd_pkg;

	// Fixed field widths of the channels and the configuration port
	localparam int ELEV_IN_W  = 16;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 16;
	localparam int DIR_W      = 3;
	localparam int GRID_W_W   = 11;
	localparam int GRID_H_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int SCALE_W    = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	// Register reset values
	localparam logic [GRID_W_W-1:0] GRID_WIDTH_RST  = 11'd1024;
	localparam logic [GRID_H_W-1:0] GRID_HEIGHT_RST = 16'd1024;

	// 1/sqrt(2) in Q0.16; axial drops are scaled by 1.0 (a 16-bit shift)
	localparam logic [SCALE_W-1:0] DIAG_SCALE = 16'd46341;

	// Window slot (row * 3 + col) of the neighbor for each direction code
	localparam logic [3:0] NB_SLOT [8] = '{4'd5, 4'd2, 4'd1, 4'd0, 4'd3, 4'd6, 4'd7, 4'd8};
	localparam logic [3:0] CENTER_SLOT = 4'd4;

	typedef logic [DIR_W-1:0] dir_t;

	// Per-cell side information traveling with the window data
	typedef struct packed {
		logic             emit;
		logic             last;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} info_t;

endpackage

[rtl/d8fd_sample_if.sv]
// Elevation sample channel: valid, ready and one elevation sample.
`timescale 1ns / 1ps

interface d8fd_sample_if;
	logic                           valid;
	logic                           ready;
	logic [d8fd_pkg::ELEV_IN_W-1:0] elevation;

	modport source (output valid, output elevation, input ready);
	modport sink (input valid, input elevation, output ready);
endinterface

[rtl/d8fd_flow_if.sv]
// Flow direction channel: valid, ready, center coordinates, direction and last flag.
`timescale 1ns / 1ps

interface d8fd_flow_if;
	logic                       valid;
	logic                       ready;
	logic [d8fd_pkg::COL_W-1:0] center_col;
	logic [d8fd_pkg::ROW_W-1:0] center_row;
	logic [d8fd_pkg::DIR_W-1:0] direction;
	logic                       last_cell;

	modport source (output valid, output center_col, output center_row, output direction,
		output last_cell, input ready);
	modport sink (input valid, input center_col, input center_row, input direction,
		input last_cell, output ready);
endinterface

[rtl/d8fd_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module d8fd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/d8fd_window.sv]
// Raster counters, grid registers, line buffers and the 3x3 elevation window.
`timescale 1ns / 1ps

module d8fd_window #(
	parameter int MAX_WIDTH = 1024,
	parameter int ELEV_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [d8fd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [d8fd_pkg::CFG_DATA_W-1:0]     cfg_data,
	d8fd_sample_if.sink                         samples,
	output logic                                cells_valid,
	input  logic                                cells_ready,
	output logic [8:0][ELEV_BITS-1:0]           cells,
	output d8fd_pkg::info_t                     info
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [d8fd_pkg::GRID_W_W-1:0] grid_width_q;
	logic [d8fd_pkg::GRID_H_W-1:0] grid_height_q;
	logic [CW-1:0]                 col_q;
	logic [d8fd_pkg::ROW_W-1:0]    row_q;

	logic                          valid_s1;
	logic [ELEV_BITS-1:0]          elev_s1;
	logic [CW-1:0]                 addr_s1;
	d8fd_pkg::info_t               info_s1;

	logic [2:0][1:0][ELEV_BITS-1:0] win_q;
	logic [2:0][ELEV_BITS-1:0]      new_col;

	logic [2*ELEV_BITS-1:0] ram_rdata;
	logic [2*ELEV_BITS-1:0] ram_wdata;

	logic [31:0] gw32, weff, gh32, heff, c32, r32, c_m1, r_m1, elev_ext;
	logic        col_end, row_end, accept, fire;
	logic [ELEV_BITS-1:0] elev_in;
	d8fd_pkg::info_t info_nx;

	// Clamp the grid size and decode the raster position
	always_comb begin
		gw32 = 32'(grid_width_q);
		gh32 = 32'(grid_height_q);
		if (gw32 < 32'd3) begin
			weff = 32'd3;
		end else if (gw32 > 32'(MAX_WIDTH)) begin
			weff = 32'(MAX_WIDTH);
		end else begin
			weff = gw32;
		end
		heff = (gh32 < 32'd3) ? 32'd3 : gh32;
		c32 = 32'(col_q);
		r32 = 32'(row_q);
		c_m1 = c32 - 32'd1;
		r_m1 = r32 - 32'd1;
		col_end = (c32 + 32'd1) >= weff;
		row_end = (r32 + 32'd1) >= heff;
		info_nx.emit = (c32 >= 32'd2) && (r32 >= 32'd2);
		info_nx.last = col_end && row_end;
		info_nx.col  = c_m1[d8fd_pkg::COL_W-1:0];
		info_nx.row  = r_m1[d8fd_pkg::ROW_W-1:0];
		elev_ext = 32'(samples.elevation);
		elev_in = elev_ext[ELEV_BITS-1:0];
	end

	assign samples.ready = !valid_s1 || cells_ready;
	assign accept        = samples.valid && samples.ready;
	assign fire          = valid_s1 && cells_ready;

	// Take configuration writes and advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= d8fd_pkg::GRID_WIDTH_RST;
			grid_height_q <= d8fd_pkg::GRID_HEIGHT_RST;
			col_q         <= '0;
			row_q         <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				d8fd_pkg::REG_GRID_WIDTH: begin
					grid_width_q <= cfg_data[d8fd_pkg::GRID_W_W-1:0];
				end
				d8fd_pkg::REG_GRID_HEIGHT: begin
					grid_height_q <= cfg_data[d8fd_pkg::GRID_H_W-1:0];
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + d8fd_pkg::ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Hold the accepted sample while the line buffer read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			elev_s1 <= elev_in;
			addr_s1 <= col_q;
			info_s1 <= info_nx;
		end
	end

	// Upper line in the high half, middle line in the low half
	assign ram_wdata = {ram_rdata[ELEV_BITS-1:0], elev_s1};

	d8fd_ram #(
		.WIDTH (2 * ELEV_BITS),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (fire),
		.waddr (addr_s1),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	assign new_col[0] = ram_rdata[2*ELEV_BITS-1:ELEV_BITS];
	assign new_col[1] = ram_rdata[ELEV_BITS-1:0];
	assign new_col[2] = elev_s1;

	// Shift the window left by one column on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (fire) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= new_col[i];
			end
		end
	end

	// Present the full neighborhood including the arriving column
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cells[i*3]     = win_q[i][0];
			cells[i*3 + 1] = win_q[i][1];
			cells[i*3 + 2] = new_col[i];
		end
	end

	assign cells_valid = valid_s1;
	assign info        = info_s1;

endmodule

[rtl/d8fd_score.sv]
// Drop and slope score for each of the eight neighbors, registered.
`timescale 1ns / 1ps

module d8fd_score #(
	parameter int ELEV_BITS = 16
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	output logic                                              in_ready,
	input  logic [8:0][ELEV_BITS-1:0]                         cells,
	input  d8fd_pkg::info_t                                   info_in,
	output logic                                              out_valid,
	input  logic                                              out_ready,
	output logic [7:0][ELEV_BITS+d8fd_pkg::SCALE_W-1:0]       scores,
	output d8fd_pkg::info_t                                   info_out
);

	localparam int SW = ELEV_BITS + d8fd_pkg::SCALE_W;

	logic                     valid_s2;
	logic [7:0][SW-1:0]       scores_s2;
	d8fd_pkg::info_t          info_s2;
	logic [7:0][SW-1:0]       scores_nx;
	logic [ELEV_BITS-1:0]     center, nb, drop;
	logic                     take;

	// Score each neighbor; no positive drop scores zero
	always_comb begin
		center = cells[d8fd_pkg::CENTER_SLOT];
		nb     = '0;
		drop   = '0;
		for (int k = 0; k < 8; k++) begin
			nb   = cells[d8fd_pkg::NB_SLOT[k]];
			drop = (center > nb) ? center - nb : '0;
			if (k % 2 == 1) begin
				scores_nx[k] = SW'(drop) * SW'(d8fd_pkg::DIAG_SCALE);
			end else begin
				scores_nx[k] = {drop, {d8fd_pkg::SCALE_W{1'b0}}};
			end
		end
	end

	assign in_ready = !valid_s2 || out_ready;
	assign take     = in_valid && in_ready;

	// Keep only interior cells; drop border transactions here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= info_in.emit;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			scores_s2 <= scores_nx;
			info_s2   <= info_in;
		end
	end

	assign out_valid = valid_s2;
	assign scores    = scores_s2;
	assign info_out  = info_s2;

endmodule

[rtl/d8fd_select.sv]
// Steepest-descent pick over eight scores and the result register.
`timescale 1ns / 1ps

module d8fd_select #(
	parameter int ELEV_BITS = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [7:0][ELEV_BITS+d8fd_pkg::SCALE_W-1:0]   scores,
	input  d8fd_pkg::info_t                               info,
	d8fd_flow_if.source                                   flows
);

	localparam int SW = ELEV_BITS + d8fd_pkg::SCALE_W;

	logic [SW-1:0]    v1 [4];
	d8fd_pkg::dir_t   c1 [4];
	logic [SW-1:0]    v2 [2];
	d8fd_pkg::dir_t   c2 [2];
	d8fd_pkg::dir_t   dir_nx;
	logic             valid_q;
	logic             take;

	// Pairwise maximum tree; the lower code keeps a tie
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			if (scores[2*j + 1] > scores[2*j]) begin
				v1[j] = scores[2*j + 1];
				c1[j] = d8fd_pkg::DIR_W'(2*j + 1);
			end else begin
				v1[j] = scores[2*j];
				c1[j] = d8fd_pkg::DIR_W'(2*j);
			end
		end
		for (int j = 0; j < 2; j++) begin
			if (v1[2*j + 1] > v1[2*j]) begin
				v2[j] = v1[2*j + 1];
				c2[j] = c1[2*j + 1];
			end else begin
				v2[j] = v1[2*j];
				c2[j] = c1[2*j];
			end
		end
		dir_nx = (v2[1] > v2[0]) ? c2[1] : c2[0];
	end

	assign in_ready = !valid_q || flows.ready;
	assign take     = in_valid && in_ready;

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (flows.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flows.center_col <= info.col;
			flows.center_row <= info.row;
			flows.direction  <= dir_nx;
			flows.last_cell  <= info.last;
		end
	end

	assign flows.valid = valid_q;

endmodule

[rtl/d8_flow_direction_window.sv]
// Top level of the D8 flow direction window.
//
// Elevation samples enter on the samples channel in raster order, column
// fastest, one transaction per sample. For every interior cell the block
// sends one transaction on the flows channel: the center column and row,
// the D8 direction code of the steepest strictly positive descent (lowest
// code on a tie, 0 for a pit or flat) and a flag on the final interior cell.
// The result for center (c-1, r-1) follows the sample at (c, r), c, r >= 2.
// Throughput: one sample per cycle while the flows receiver is ready. A
// sample passes the line buffer read into the input stage, neighbor scoring
// and the direction pick into the result register.
// Each stage holds its data while the next one stalls, so the block keeps
// taking samples until its three stages are full; a stall of the flows
// receiver backs up to samples.ready only then.
// Configuration: register 0 grid_width (clamped to 3..MAX_WIDTH), register 1
// grid_height (at least 3). Write only while idle; a write restarts the grid.
// Reset: grid is 1024 x 1024, position at column 0 row 0, pipeline empty. The
// line buffers are not cleared; entries read before being written only feed
// rows 0 and 1, which never produce a result.
`timescale 1ns / 1ps

module d8_flow_direction_window #(
	parameter int MAX_WIDTH = 1024,
	parameter int ELEV_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [d8fd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [d8fd_pkg::CFG_DATA_W-1:0] cfg_data,
	d8fd_sample_if.sink                     samples,
	d8fd_flow_if.source                     flows
);

	localparam int SW = ELEV_BITS + d8fd_pkg::SCALE_W;

	logic                           cells_valid, cells_ready;
	logic [8:0][ELEV_BITS-1:0]      cells;
	d8fd_pkg::info_t                cells_info;
	logic                           score_valid, score_ready;
	logic [7:0][SW-1:0]             scores;
	d8fd_pkg::info_t                score_info;

	d8fd_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.ELEV_BITS (ELEV_BITS)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.samples     (samples),
		.cells_valid (cells_valid),
		.cells_ready (cells_ready),
		.cells       (cells),
		.info        (cells_info)
	);

	d8fd_score #(
		.ELEV_BITS (ELEV_BITS)
	) u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cells_valid),
		.in_ready  (cells_ready),
		.cells     (cells),
		.info_in   (cells_info),
		.out_valid (score_valid),
		.out_ready (score_ready),
		.scores    (scores),
		.info_out  (score_info)
	);

	d8fd_select #(
		.ELEV_BITS (ELEV_BITS)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (score_valid),
		.in_ready (score_ready),
		.scores   (scores),
		.info     (score_info),
		.flows    (flows)
	);

endmodule

[bench/tb.sv]
// Self-checking bench for the D8 flow direction window: raster samples in, flow codes checked.
`timescale 1ns / 1ps

module tb;

	localparam int HALF_PERIOD_NS = 6;     // 12 ns clock
	localparam int LINE_DEPTH     = 1024;  // MAX_WIDTH of the block as built
	localparam int DRAIN_CYCLES   = 8;
	localparam int STALL_LIMIT    = 4000;  // cycles without any transaction
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int HOLD_AT_FLOW   = 40;
	localparam int TOTAL_ITEMS    = 1450;
	localparam int WIDE_GRID      = 150;
	localparam longint unsigned AXIAL_SCALE = 64'd65536;
	localparam d8fd_pkg::dir_t DIR_EAST = '0;  // also the code of a pit or flat

	// Neighbor offsets per direction code, as (dx, dy)
	localparam int STEP_DX [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
	localparam int STEP_DY [8] = '{0, -1, -1, -1, 0, 1, 1, 1};

	// Hand-made 5x5 grid: both elevation extremes, flats, axial ties,
	// and a diagonal drop that beats a smaller axial drop
	localparam logic [d8fd_pkg::ELEV_IN_W-1:0] DIRECTED_GRID [25] = '{
		16'd0,     16'd0,     16'd0,     16'd0,   16'd0,
		16'd0,     16'd65535, 16'd65535, 16'd100, 16'd0,
		16'd65535, 16'd65535, 16'd65535, 16'd100, 16'd86,
		16'd100,   16'd100,   16'd100,   16'd100, 16'd100,
		16'd85,    16'd100,   16'd115,   16'd0,   16'd65535
	};

	typedef enum int {ELEV_FULL, ELEV_TIGHT, ELEV_RIDGE, ELEV_EXTREME} elev_mode_e;

	typedef struct {
		logic [d8fd_pkg::COL_W-1:0] col;
		logic [d8fd_pkg::ROW_W-1:0] row;
		d8fd_pkg::dir_t             dir;
		logic                       last;
	} flow_cell_t;

	// Scoreboard: tracks line buffers, window and raster position, and holds
	// the flow cells still owed by the block
	class FlowBoard;
		logic [d8fd_pkg::ELEV_IN_W-1:0] row_above [LINE_DEPTH];
		logic [d8fd_pkg::ELEV_IN_W-1:0] row_current [LINE_DEPTH];
		// [0 = row r-2 .. 2 = row r][0 = col c-2 .. 2 = col c]
		logic [d8fd_pkg::ELEV_IN_W-1:0] win [3][3];
		int unsigned                    col_pos;
		int unsigned                    row_pos;
		logic [d8fd_pkg::GRID_W_W-1:0]  width_reg;
		logic [d8fd_pkg::GRID_H_W-1:0]  height_reg;
		flow_cell_t                     owed [$];

		function new();
			foreach (row_above[i]) begin
				row_above[i] = '0;
				row_current[i] = '0;
			end
			foreach (win[i, j])
				win[i][j] = '0;
			col_pos = 0;
			row_pos = 0;
			width_reg = d8fd_pkg::GRID_WIDTH_RST;
			height_reg = d8fd_pkg::GRID_HEIGHT_RST;
		endfunction

		// Any register write restarts the grid
		function void note_config(logic [d8fd_pkg::CFG_IDX_W-1:0] idx,
				logic [d8fd_pkg::CFG_DATA_W-1:0] data);
			if (idx == d8fd_pkg::REG_GRID_WIDTH)
				width_reg = data[d8fd_pkg::GRID_W_W-1:0];
			else if (idx == d8fd_pkg::REG_GRID_HEIGHT)
				height_reg = data[d8fd_pkg::GRID_H_W-1:0];
			col_pos = 0;
			row_pos = 0;
		endfunction

		// Pick the steepest strictly positive descent; first code wins a tie
		function d8fd_pkg::dir_t steepest();
			longint unsigned best;
			longint unsigned drop;
			longint unsigned score;
			logic [d8fd_pkg::ELEV_IN_W-1:0] mid;
			logic [d8fd_pkg::ELEV_IN_W-1:0] nb;
			d8fd_pkg::dir_t code;
			best = 0;
			code = DIR_EAST;
			mid = win[1][1];
			for (int k = 0; k < 8; k++) begin
				nb = win[1 + STEP_DY[k]][1 + STEP_DX[k]];
				if (mid > nb) begin
					drop = mid - nb;
					score = drop * ((k % 2 == 1) ? longint'(d8fd_pkg::DIAG_SCALE) : AXIAL_SCALE);
					if (score > best) begin
						best = score;
						code = d8fd_pkg::dir_t'(k);
					end
				end
			end
			return code;
		endfunction

		function void note_sample(logic [d8fd_pkg::ELEV_IN_W-1:0] elev);
			int unsigned w;
			int unsigned h;
			int unsigned c;
			int unsigned r;
			logic [d8fd_pkg::ELEV_IN_W-1:0] above;
			logic [d8fd_pkg::ELEV_IN_W-1:0] mid;
			flow_cell_t entry;
			w = (width_reg < 3) ? 3 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
			h = (height_reg < 3) ? 3 : height_reg;
			c = col_pos;
			r = row_pos;
			above = row_above[c];
			mid = row_current[c];
			// slide the window one column and push the line buffers down
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = above;
			win[1][2] = mid;
			win[2][2] = elev;
			row_above[c] = mid;
			row_current[c] = elev;
			// interior center (c-1, r-1) is complete
			if (c >= 2 && r >= 2) begin
				entry.col = d8fd_pkg::COL_W'(c - 1);
				entry.row = d8fd_pkg::ROW_W'(r - 1);
				entry.dir = steepest();
				entry.last = (c + 1 >= w) && (r + 1 >= h);
				owed = {owed, entry};
			end
			// advance the raster position, wrap at the end of the grid
			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos = (r + 1 >= h) ? 0 : r + 1;
			end else begin
				col_pos = c + 1;
			end
		endfunction

		// Compare a flow transaction with the oldest owed cell; empty string if it matches
		function string check_flow(flow_cell_t got);
			flow_cell_t want;
			if (owed.size() == 0)
				return $sformatf("unexpected flow col %0d row %0d dir %0d last %0d",
					got.col, got.row, got.dir, got.last);
			want = owed.pop_front();
			if (got.col !== want.col || got.row !== want.row || got.dir !== want.dir
					|| got.last !== want.last)
				return $sformatf("flow col/row/dir/last %0d/%0d/%0d/%0d, expected %0d/%0d/%0d/%0d",
					got.col, got.row, got.dir, got.last,
					want.col, want.row, want.dir, want.last);
			return "";
		endfunction

		function int outstanding();
			return owed.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [d8fd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [d8fd_pkg::CFG_DATA_W-1:0] cfg_data;

	d8fd_sample_if samples_ch ();
	d8fd_flow_if   flows_ch ();

	d8_flow_direction_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.flows     (flows_ch)
	);

	FlowBoard board;
	int       mismatches = 0;
	int       sent_count = 0;
	int       flow_count = 0;
	int       grid_settings = 0;
	int       quiet_cycles = 0;

	always #(HALF_PERIOD_NS) clk = ~clk;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	task automatic write_reg(input logic [d8fd_pkg::CFG_IDX_W-1:0] idx,
			input logic [d8fd_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.note_config(idx, data);
	endtask

	task automatic set_grid(input logic [d8fd_pkg::CFG_DATA_W-1:0] wdata,
			input logic [d8fd_pkg::CFG_DATA_W-1:0] hdata);
		write_reg(d8fd_pkg::REG_GRID_WIDTH, wdata);
		write_reg(d8fd_pkg::REG_GRID_HEIGHT, hdata);
		grid_settings++;
	endtask

	// Offer one sample after a random gap, or at once when steady; return once the transaction is taken
	task automatic send_sample(input logic [d8fd_pkg::ELEV_IN_W-1:0] elev, input bit steady);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_ch.valid <= 1'b1;
		samples_ch.elevation <= elev;
		@(posedge clk);
		while (!samples_ch.ready) @(posedge clk);
		board.note_sample(elev);
		sent_count++;
	endtask

	function automatic logic [d8fd_pkg::ELEV_IN_W-1:0] draw_elevation(input elev_mode_e mode);
		case (mode)
			ELEV_TIGHT: return d8fd_pkg::ELEV_IN_W'($urandom_range(0, 3));
			ELEV_RIDGE: return d8fd_pkg::ELEV_IN_W'(30000 + $urandom_range(0, 24));
			ELEV_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return d8fd_pkg::ELEV_IN_W'(1);
					default: return d8fd_pkg::ELEV_IN_W'($urandom_range(0, 65535));
				endcase
			end
			default: return d8fd_pkg::ELEV_IN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Stream n samples, mostly of one flavor, with idle and steady stretches
	task automatic run_random(input int n, input elev_mode_e mode, input bit steady_start);
		bit steady;
		elev_mode_e pick;
		steady = steady_start;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0)
				steady = !steady;
			pick = ($urandom_range(0, 9) == 0) ? ELEV_FULL : mode;
			send_sample(draw_elevation(pick), steady);
		end
	endtask

	// Drop valid, wait for every owed cell, then let the pipeline empty
	task automatic settle();
		samples_ch.valid <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Flow receiver: random ready gaps, steady stretches, one long hold-off
	initial begin
		int gap;
		bit steady;
		bit held;
		flow_cell_t got;
		string msg;
		steady = 1'b0;
		held = 1'b0;
		flows_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 19);
			if (!held && flow_count == HOLD_AT_FLOW) begin
				gap = HOLD_CYCLES;
				held = 1'b1;
			end
			if (gap > 0) begin
				flows_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			flows_ch.ready <= 1'b1;
			@(posedge clk);
			while (!flows_ch.valid) @(posedge clk);
			got.col = flows_ch.center_col;
			got.row = flows_ch.center_row;
			got.dir = flows_ch.direction;
			got.last = flows_ch.last_cell;
			msg = board.check_flow(got);
			if (msg != "")
				report(msg);
			flow_count++;
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (flows_ch.valid && flows_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction, %0d cells still owed",
				quiet_cycles, board.outstanding());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Main sequence
	initial begin
		int w;
		int h;
		int n;
		elev_mode_e mode;
		board = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = d8fd_pkg::REG_GRID_WIDTH;
		cfg_data = '0;
		samples_ch.valid = 1'b0;
		samples_ch.elevation = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset grid size: the first row must not produce any flow cell
		run_random(120, ELEV_FULL, 1'b1);
		settle();

		// wide grid, three rows tall, plus the start of the next one
		set_grid(d8fd_pkg::CFG_DATA_W'(WIDE_GRID), d8fd_pkg::CFG_DATA_W'(3));
		run_random(3 * WIDE_GRID + 5, ELEV_FULL, 1'b1);
		settle();

		// directed 5x5 grid
		set_grid(d8fd_pkg::CFG_DATA_W'(5), d8fd_pkg::CFG_DATA_W'(5));
		foreach (DIRECTED_GRID[i])
			send_sample(DIRECTED_GRID[i], 1'b0);
		settle();

		// zero in both registers clamps to the smallest grid; run several grids
		set_grid('0, '0);
		run_random(45, ELEV_TIGHT, 1'b0);
		settle();

		// tallest grid, only a few rows of it
		set_grid(d8fd_pkg::CFG_DATA_W'(3), '1);
		run_random(60, ELEV_RIDGE, 1'b0);
		settle();

		// random small grids, whole and partial, with junk in the unused width bits
		while (sent_count < TOTAL_ITEMS) begin
			w = $urandom_range(3, 12);
			h = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 65535) : $urandom_range(3, 9);
			if (h > 9)
				n = w * $urandom_range(3, 8);
			else if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, 3 * w);
			else
				n = w * h * $urandom_range(1, 2) + $urandom_range(0, w);
			if (n > TOTAL_ITEMS - sent_count)
				n = TOTAL_ITEMS - sent_count;
			mode = elev_mode_e'($urandom_range(0, 3));
			set_grid({5'($urandom_range(0, 31)), 11'(w)}, d8fd_pkg::CFG_DATA_W'(h));
			run_random(n, mode, $urandom_range(0, 3) == 0);
			settle();
		end

		$display("Covered %0d samples and %0d flow cells over %0d grid settings", sent_count,
			flow_count, grid_settings);
		$display("Widths 3 to %0d, heights 3 to 65535, clamped sizes and a long receiver hold-off",
			WIDE_GRID);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
